@@ hw/rtl/gsb_pkg.sv @@
// ----------------------------------------------------------------------------
// gsb_pkg
// Shared types and constants of the growable symbol buffer.
// ----------------------------------------------------------------------------
package gsb_pkg;

  localparam int unsigned DEFAULT_MAX_CAPACITY = 32767;
  // Largest value that the 15-bit count fields can carry.
  localparam int unsigned FIELD_MAX            = 32767;
  localparam int unsigned CNT_W                = 15;
  localparam int unsigned SYM_W                = 8;
  localparam int unsigned START_CAP_RESET      = 200;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned CFG_IDX_W   = 2;

  // Multiplicative growth: inc = (limit - cap) * pct / 100.
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned PROD_W      = CNT_W + PCT_W;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned SCALED_W    = PROD_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [PCT_W-1:0]   PCT_MAX   = PCT_W'(100);
  // floor(2^22 / 100); the quotient it gives is low by at most one.
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(41943);

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_GET       = 3'd1,
    OP_RETRACT   = 3'd2,
    OP_TO_MARK   = 3'd3,
    OP_SET_MARK  = 3'd4,
    OP_RESET     = 3'd5,
    OP_PACK      = 3'd6,
    OP_QUERY     = 3'd7
  } op_t;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_MUL   = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GROW_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CAP   = 2'd2;

  // Result, last field in the lowest bits.
  typedef struct packed {
    logic             is_full;
    logic [CNT_W-1:0] current_capacity;
    logic [CNT_W-1:0] mark_position;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] read_position;
    logic             end_of_buffer;
    logic [SYM_W-1:0] symbol_out;
    logic             status;
  } result_t;

endpackage

@@ hw/rtl/gsb_ram.sv @@
// ----------------------------------------------------------------------------
// gsb_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gsb_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/growable_symbol_buffer.sv @@
// ----------------------------------------------------------------------------
// growable_symbol_buffer
// Byte buffer for a scanner with append, read, retract, mark and growth.
// ----------------------------------------------------------------------------
// Every input transaction carries an opcode in s_tuser and returns exactly one
// result transaction with a status and the buffer's query values. A get waits
// for the byte from the registered read port of the symbol RAM, and an add
// that has to grow the capacity in multiplicative mode passes in turn through
// the percent multiply, the reciprocal multiply by 1/100 and its correction.
// The result register frees the input side, once the state machine is back
// in idle, as soon as the result is taken or when it is empty.
// The symbol RAM has no clearing pass: a get only reads below the fill count.
// Configuration writes are taken while no transaction is in flight.
module growable_symbol_buffer import gsb_pkg::*; #(
  parameter int unsigned MAX_CAPACITY = DEFAULT_MAX_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // symbol_in[7:0], mark_value[22:8]
  input  logic [2:0]             s_tuser,   // opcode[2:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status[0], symbol_out[8:1], end_of_buffer[9], read_position[24:10],
  // fill_count[39:25], mark_position[54:40], current_capacity[69:55], is_full[70]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned CAP_LIMIT   = (MAX_CAPACITY < FIELD_MAX) ? MAX_CAPACITY : FIELD_MAX;
  localparam int unsigned STORE_DEPTH = CAP_LIMIT;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] LIMIT  = CNT_W'(CAP_LIMIT);
  localparam logic [CNT_W-1:0] RESET_CAP =
    CNT_W'((START_CAP_RESET < CAP_LIMIT) ? START_CAP_RESET : CAP_LIMIT);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_FIX   = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  write_count, write_count_next;
  logic [CNT_W-1:0]  read_offset, read_offset_next;
  logic [CNT_W-1:0]  mark_pos, mark_pos_next;
  logic [CNT_W-1:0]  capacity_now, capacity_now_next;
  logic              eob_flag, eob_flag_next;
  logic [1:0]        grow_mode;
  logic [SYM_W-1:0]  grow_factor;
  logic [SYM_W-1:0]  held_symbol;
  logic [PROD_W-1:0] prod_pct;
  logic [SCALED_W-1:0] prod_scaled;
  logic              out_valid;
  result_t           out_data;

  op_t               op;
  logic [SYM_W-1:0]  sym_in;
  logic [CNT_W-1:0]  mark_in;
  logic              accept;
  logic              cfg_write;
  logic              load_out;
  logic              res_status;
  logic [SYM_W-1:0]  res_symbol;
  result_t           res;

  logic [1:0]        mode_eff;
  logic [CNT_W:0]    add_sum;
  logic [CNT_W:0]    pack_sum;
  logic [PCT_W-1:0]  pct;
  logic [CNT_W-1:0]  headroom;
  logic [CNT_W-1:0]  quot;
  logic [PROD_W-1:0] rem;
  logic [CNT_W-1:0]  inc;
  logic [CNT_W-1:0]  cfg_cap;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [SYM_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [SYM_W-1:0]  mem_rdata;

  assign op      = op_t'(s_tuser);
  assign sym_in  = s_tdata[SYM_W-1:0];
  assign mark_in = s_tdata[SYM_W +: CNT_W];

  assign s_tready  = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;

  // A zero factor or the reserved mode code means no growth at all.
  assign mode_eff = (grow_factor == '0 || grow_mode == MODE_RSVD) ? MODE_FIXED : grow_mode;
  assign add_sum  = {1'b0, capacity_now} + (CNT_W+1)'(grow_factor);
  assign pack_sum = {1'b0, write_count} + (CNT_W+1)'(1);
  assign pct      = (grow_factor > SYM_W'(PCT_MAX)) ? PCT_MAX : grow_factor[PCT_W-1:0];
  assign headroom = LIMIT - capacity_now;

  // The reciprocal quotient may be one short; one compare fixes it.
  assign quot = prod_scaled[RECIP_SHIFT +: CNT_W];
  assign rem  = prod_pct - (PROD_W'(quot) * PROD_W'(PCT_MAX));
  assign inc  = (rem >= PROD_W'(PCT_MAX)) ? quot + CNT_W'(1) : quot;

  assign cfg_cap = (cfg_data[CNT_W-1:0] > LIMIT) ? LIMIT :
                   (cfg_data[CNT_W-1:0] < write_count) ? write_count : cfg_data[CNT_W-1:0];

  always_comb begin
    state_next        = state;
    write_count_next  = write_count;
    read_offset_next  = read_offset;
    mark_pos_next     = mark_pos;
    capacity_now_next = capacity_now;
    eob_flag_next     = eob_flag;
    res_status        = 1'b0;
    res_symbol        = '0;
    load_out          = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = write_count[ADDR_W-1:0];
    mem_wdata         = sym_in;
    mem_re            = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (op)
            OP_ADD: begin
              if (write_count < capacity_now) begin
                mem_we           = 1'b1;
                write_count_next = write_count + CNT_W'(1);
              end else begin
                case (mode_eff)
                  MODE_ADD: begin
                    if (add_sum <= {1'b0, LIMIT}) begin
                      capacity_now_next = add_sum[CNT_W-1:0];
                      mem_we            = 1'b1;
                      write_count_next  = write_count + CNT_W'(1);
                    end else begin
                      res_status = 1'b1;
                    end
                  end
                  MODE_MUL: begin
                    if (capacity_now >= LIMIT) begin
                      res_status = 1'b1;
                    end else begin
                      load_out   = 1'b0;
                      state_next = ST_SCALE;
                    end
                  end
                  default: res_status = 1'b1;
                endcase
              end
            end
            OP_GET: begin
              if (read_offset >= write_count) begin
                eob_flag_next = 1'b1;
                res_status    = 1'b1;
              end else begin
                eob_flag_next    = 1'b0;
                read_offset_next = read_offset + CNT_W'(1);
                mem_re           = 1'b1;
                load_out         = 1'b0;
                state_next       = ST_READ;
              end
            end
            OP_RETRACT: begin
              if (read_offset == '0) begin
                res_status = 1'b1;
              end else begin
                read_offset_next = read_offset - CNT_W'(1);
              end
            end
            OP_TO_MARK: read_offset_next = mark_pos;
            OP_SET_MARK: begin
              if (mark_in <= write_count) begin
                mark_pos_next = mark_in;
              end else begin
                res_status = 1'b1;
              end
            end
            OP_RESET: begin
              write_count_next = '0;
              read_offset_next = '0;
              mark_pos_next    = '0;
              eob_flag_next    = 1'b0;
            end
            OP_PACK: begin
              if (pack_sum <= {1'b0, LIMIT}) begin
                capacity_now_next = pack_sum[CNT_W-1:0];
              end else begin
                res_status = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_symbol = mem_rdata;
        load_out   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCALE: state_next = ST_FIX;
      ST_FIX: begin
        // The buffer was full, so the grown capacity always leaves room.
        capacity_now_next = (inc == '0) ? LIMIT : capacity_now + inc;
        mem_we            = 1'b1;
        mem_wdata         = held_symbol;
        write_count_next  = write_count + CNT_W'(1);
        load_out          = 1'b1;
        state_next        = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res.status           = res_status;
    res.symbol_out       = res_symbol;
    res.end_of_buffer    = eob_flag_next;
    res.read_position    = read_offset_next;
    res.fill_count       = write_count_next;
    res.mark_position    = mark_pos_next;
    res.current_capacity = capacity_now_next;
    res.is_full          = (write_count_next == capacity_now_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_count  <= '0;
      read_offset  <= '0;
      mark_pos     <= '0;
      capacity_now <= RESET_CAP;
      eob_flag     <= 1'b0;
      grow_mode    <= MODE_FIXED;
      grow_factor  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      write_count  <= write_count_next;
      read_offset  <= read_offset_next;
      mark_pos     <= mark_pos_next;
      capacity_now <= (cfg_write && cfg_index == CFG_START_CAP) ? cfg_cap : capacity_now_next;
      eob_flag     <= eob_flag_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_GROW_MODE:   grow_mode    <= cfg_data[1:0];
          CFG_GROW_FACTOR: grow_factor  <= cfg_data[SYM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
    if (accept) begin
      held_symbol <= sym_in;
      prod_pct    <= PROD_W'(headroom) * PROD_W'(pct);
    end
    if (state == ST_SCALE) begin
      prod_scaled <= SCALED_W'(prod_pct) * SCALED_W'(RECIP_100);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_data);

  gsb_ram #(
    .WIDTH  (SYM_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (read_offset[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

endmodule

@@ hw/rtl/gsb_checker.sv @@
// ----------------------------------------------------------------------------
// gsb_checker
// Port-level checks of the growable symbol buffer, bound to the top level.
// ----------------------------------------------------------------------------
module gsb_checker import gsb_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  result_t res;

  assign res = m_tdata[$bits(result_t)-1:0];

  // The full flag reports the count against the capacity of the same result.
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.is_full == (res.fill_count == res.current_capacity)))
    else $error("is_full disagrees with fill count and capacity");

  // Read offset never passes the count, and the count never passes capacity.
  a_ordering: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.read_position <= res.fill_count &&
                  res.fill_count <= res.current_capacity))
    else $error("offset ordering broken");

  // A nonzero byte comes only from a get that succeeded.
  a_symbol_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.symbol_out != '0) |-> (!res.status && !res.end_of_buffer))
    else $error("symbol returned by a refused transaction");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind growable_symbol_buffer gsb_checker u_gsb_checker (.*);
